// File: hw/rtl/assert_macros.svh
// ------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the arm selector checkers.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic property check, disabled during reset
`define UCB1_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A stalled beat keeps valid high and its payload unchanged
`define UCB1_HOLD(lbl, clk, rst, vld, rdy, data, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) \
    ((vld) && !(rdy)) |=> ((vld) && $stable(data))) else $error(msg);

`endif

// File: hw/rtl/ucb1_pkg.sv
// ------------------------------------------------------------------------
// ucb1_pkg
// Constants and types shared by the UCB1 arm selector and its checker.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ucb1_pkg;

  // build-time arm count default
  localparam int DEF_MAX_ARMS = 32;

  // field and store widths
  localparam int REWARD_W = 17;
  localparam int COUNT_W  = 32;
  localparam int ARM_W    = 5;
  localparam int NARMS_W  = 6;
  localparam int SUM_W    = 48;
  localparam int PULL_W   = 32;
  localparam int ENTRY_W  = SUM_W + PULL_W;
  localparam int IDX_W    = 32;

  // ln / root datapath widths
  localparam int LN_W     = 22;   // 2*ln(x) in Q16.16 stays below 2^22
  localparam int MANT_W   = 31;   // Q1.30 mantissa
  localparam int ROOT_W   = 38;   // (arg << 16) stays below 2^38

  // iteration counts
  localparam int MEAN_STEPS = SUM_W;
  localparam int ARG_STEPS  = LN_W;
  localparam int ROOT_STEPS = 19;
  localparam int FRAC_BITS  = 16;

  localparam logic [15:0]       LN2_Q16     = 16'd45426;
  localparam logic [ROOT_W-1:0] ROOT_TOP    = 38'h10_0000_0000;
  localparam logic [NARMS_W-1:0] NARMS_RST  = 6'd5;
  localparam logic [IDX_W-1:0]  IDX_MAX     = '1;
  localparam logic [SUM_W-1:0]  SUM_MAX     = '1;
  localparam logic [PULL_W-1:0] PULL_MAX    = '1;

  // register map (word index)
  localparam logic REG_NUM_ARMS = 1'b0;

  // sequencer states
  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_RDP  = 12'b0000_0000_0010,
    S_UPD  = 12'b0000_0000_0100,
    S_NORM = 12'b0000_0000_1000,
    S_SQ   = 12'b0000_0001_0000,
    S_ACC  = 12'b0000_0010_0000,
    S_LNM  = 12'b0000_0100_0000,
    S_ARD  = 12'b0000_1000_0000,
    S_ALD  = 12'b0001_0000_0000,
    S_DIV  = 12'b0010_0000_0000,
    S_CMP  = 12'b0100_0000_0000,
    S_FIN  = 12'b1000_0000_0000
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/ucb1_arm_selector_unit.sv
// ------------------------------------------------------------------------
// ucb1_arm_selector_unit
// UCB1 bandit arm selector with per-arm reward sums and pull counts in RAM.
// ------------------------------------------------------------------------
// Usage:
//  Input beat (in_valid/in_ready): reward of the arm chosen last and the
//  running pull count. Output beat (out_valid/out_ready): next arm to pull.
//  One output beat per input beat, in order. num_arms is set over the APB
//  port at address 0, by the user only while the unit is idle; the block
//  itself does not enforce this. From the accepted beat to out_valid: a
//  pull count of zero goes straight to the final state; a count below
//  num_arms reads and updates the RAM, then finishes; otherwise RAM read
//  and update, normalising count+1, log2 squaring, the ln scaling, then
//  per arm in use a RAM read, a load, the 48-step mean divider (the longest
//  per-arm step) alongside the bonus divider and root, and a compare, then
//  a final state. One item is worked on at a time.
//  Reset clears every arm (valid bits), the last arm and sets num_arms 5.
//  A result waits in the output register while the next beat is taken; a
//  finished item holds until the receiver frees that register.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ucb1_arm_selector_unit #(
  parameter int MAX_ARMS = ucb1_pkg::DEF_MAX_ARMS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [ucb1_pkg::REWARD_W-1:0] reward,
  input  wire logic [ucb1_pkg::COUNT_W-1:0]  pull_count,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [ucb1_pkg::ARM_W-1:0]         chosen_arm,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  import ucb1_pkg::*;

  localparam int AW = (MAX_ARMS > 1) ? $clog2(MAX_ARMS) : 1;
  localparam int NW = AW + 1;

  state_t state, state_next;

  // config register
  logic [NARMS_W-1:0] num_arms;
  logic [NW-1:0]      n_use;

  // per-arm store: {sum, pulls}
  logic [ENTRY_W-1:0] mem [MAX_ARMS];
  logic [MAX_ARMS-1:0] vld;
  logic [ENTRY_W-1:0] rd_q;
  logic               rd_vld_q;
  logic [AW-1:0]      rd_addr;
  logic               mem_we;
  logic [ENTRY_W-1:0] wr_data;

  // item registers
  logic [REWARD_W-1:0] rew_q;
  logic [COUNT_W-1:0]  cnt_in_q;
  logic [AW-1:0]       last_arm;
  logic [5:0]          cnt;

  // ln path
  logic [COUNT_W:0]    nx;
  logic [5:0]          lk;
  logic [MANT_W-1:0]   lm;
  logic [2*MANT_W-1:0] sq_q;
  logic [FRAC_BITS-1:0] frac;
  logic [LN_W-1:0]     ln2x;
  logic [37:0]         ln_prod;
  logic [31:0]         sq_top;

  // arm loop
  logic [AW-1:0]       ai;
  logic [IDX_W-1:0]    best;
  logic [AW-1:0]       best_arm;
  logic [SUM_W-1:0]    md;
  logic [PULL_W-1:0]   mr;
  logic [LN_W-1:0]     ad;
  logic [PULL_W-1:0]   ar;
  logic [PULL_W-1:0]   ap;
  logic [ROOT_W-1:0]   rv, rres, rbit;

  logic accept, lt_n, last_ai;
  logic [SUM_W-1:0]  old_sum, sum_new;
  logic [PULL_W-1:0] old_pulls, pulls_new;
  logic [SUM_W:0]    sum_add;

  // divider / root step logic
  logic [PULL_W:0]   m_trial, a_trial;
  logic              m_ge, a_ge;
  logic [ROOT_W-1:0] rv_cur, rres_cur, rbit_cur, r_trb;
  logic              r_ge, root_first, root_on;
  logic [IDX_W-1:0]  mean_sat, arm_idx;
  logic [IDX_W:0]    idx_sum;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign pready   = 1'b1;

  // arms in use, clamped to 1..MAX_ARMS
  always_comb begin
    if (num_arms == '0) begin
      n_use = NW'(1);
    end else if (32'(num_arms) > 32'(MAX_ARMS)) begin
      n_use = NW'(MAX_ARMS);
    end else begin
      n_use = NW'(num_arms);
    end
  end

  assign lt_n    = (cnt_in_q < 32'(n_use));
  assign last_ai = ((32'(ai) + 32'd1) == 32'(n_use));

  // APB read-back
  assign prdata = (paddr[2] == REG_NUM_ARMS) ? 32'(num_arms) : 32'd0;

  // read-modify-write of the previous arm
  assign old_sum   = rd_vld_q ? rd_q[ENTRY_W-1:PULL_W] : '0;
  assign old_pulls = rd_vld_q ? rd_q[PULL_W-1:0] : '0;
  assign pulls_new = (old_pulls == PULL_MAX) ? old_pulls : old_pulls + 32'd1;
  assign sum_add   = {1'b0, old_sum} + (SUM_W + 1)'(rew_q);
  always_comb begin
    if (lt_n) begin
      sum_new = SUM_W'(rew_q);
    end else if (sum_add[SUM_W]) begin
      sum_new = SUM_MAX;
    end else begin
      sum_new = sum_add[SUM_W-1:0];
    end
  end
  assign mem_we  = (state == S_UPD);
  assign wr_data = {sum_new, pulls_new};
  assign rd_addr = (state == S_ARD) ? ai : last_arm;

  // log2 mantissa squaring
  assign sq_top  = sq_q[2*MANT_W-1:MANT_W-1];
  assign ln_prod = 38'({lk, frac}) * 38'(LN2_Q16);

  // mean divider step
  assign m_trial = {mr, md[SUM_W-1]};
  assign m_ge    = (m_trial >= {1'b0, ap});
  // bonus argument divider step
  assign a_trial = {ar, ad[LN_W-1]};
  assign a_ge    = (a_trial >= {1'b0, ap});

  // square root step
  assign root_on    = (32'(cnt) >= ARG_STEPS) && (32'(cnt) < ARG_STEPS + ROOT_STEPS);
  assign root_first = (32'(cnt) == ARG_STEPS);
  assign rv_cur     = root_first ? {ad, 16'd0} : rv;
  assign rres_cur   = root_first ? '0 : rres;
  assign rbit_cur   = root_first ? ROOT_TOP : rbit;
  assign r_trb      = rres_cur + rbit_cur;
  assign r_ge       = (rv_cur >= r_trb);

  // index of the current arm
  assign mean_sat = (md[SUM_W-1:IDX_W] != '0) ? IDX_MAX : md[IDX_W-1:0];
  assign idx_sum  = {1'b0, mean_sat} + {1'b0, rres[IDX_W-1:0]};
  always_comb begin
    if (ap == '0) begin
      arm_idx = IDX_MAX;
    end else if (idx_sum[IDX_W]) begin
      arm_idx = IDX_MAX;
    end else begin
      arm_idx = idx_sum[IDX_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (pull_count == '0) ? S_FIN : S_RDP;
        end
      end
      S_RDP:  state_next = S_UPD;
      S_UPD:  state_next = lt_n ? S_FIN : S_NORM;
      S_NORM: state_next = nx[COUNT_W] ? S_SQ : S_NORM;
      S_SQ:   state_next = S_ACC;
      S_ACC:  state_next = (32'(cnt) == FRAC_BITS - 1) ? S_LNM : S_SQ;
      S_LNM:  state_next = S_ARD;
      S_ARD:  state_next = S_ALD;
      S_ALD:  state_next = S_DIV;
      S_DIV:  state_next = (32'(cnt) == MEAN_STEPS - 1) ? S_CMP : S_DIV;
      S_CMP:  state_next = last_ai ? S_FIN : S_ARD;
      S_FIN: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      num_arms  <= NARMS_RST;
      last_arm  <= '0;
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (psel && penable && pwrite && pready && (paddr[2] == REG_NUM_ARMS)) begin
        num_arms <= pwdata[NARMS_W-1:0];
      end
      if (accept && (pull_count == '0)) begin
        vld      <= '0;
        last_arm <= '0;
      end
      if (mem_we) begin
        vld[last_arm] <= 1'b1;
        if (lt_n) begin
          last_arm <= cnt_in_q[AW-1:0];
        end
      end
      if ((state == S_CMP) && last_ai) begin
        last_arm <= (arm_idx > best) ? ai : best_arm;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if ((state == S_FIN) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if ((state == S_FIN) && (!out_valid || out_ready)) begin
      chosen_arm <= ARM_W'(last_arm);
    end
  end

  // per-arm RAM, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[last_arm] <= wr_data;
    end
    rd_q     <= mem[rd_addr];
    rd_vld_q <= vld[rd_addr];
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          rew_q    <= reward;
          cnt_in_q <= pull_count;
        end
      end
      S_UPD: begin
        nx <= {1'b0, cnt_in_q} + 33'd1;
        lk <= 6'd32;
      end
      S_NORM: begin
        if (nx[COUNT_W]) begin
          lm  <= nx[COUNT_W:2];
          cnt <= '0;
        end else begin
          nx <= {nx[COUNT_W-1:0], 1'b0};
          lk <= lk - 6'd1;
        end
      end
      S_SQ: begin
        sq_q <= lm * lm;
      end
      S_ACC: begin
        if (sq_top[31]) begin
          lm   <= sq_top[31:1];
          frac <= {frac[FRAC_BITS-2:0], 1'b1};
        end else begin
          lm   <= sq_top[30:0];
          frac <= {frac[FRAC_BITS-2:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
      end
      S_LNM: begin
        ln2x     <= {ln_prod[36:16], 1'b0};
        ai       <= '0;
        best     <= '0;
        best_arm <= '0;
      end
      S_ALD: begin
        md  <= rd_vld_q ? rd_q[ENTRY_W-1:PULL_W] : '0;
        ap  <= rd_vld_q ? rd_q[PULL_W-1:0] : '0;
        mr  <= '0;
        ad  <= ln2x;
        ar  <= '0;
        cnt <= '0;
      end
      S_DIV: begin
        mr <= m_ge ? PULL_W'(m_trial - {1'b0, ap}) : m_trial[PULL_W-1:0];
        md <= {md[SUM_W-2:0], m_ge};
        if (32'(cnt) < ARG_STEPS) begin
          ar <= a_ge ? PULL_W'(a_trial - {1'b0, ap}) : a_trial[PULL_W-1:0];
          ad <= {ad[LN_W-2:0], a_ge};
        end
        if (root_on) begin
          rv   <= r_ge ? rv_cur - r_trb : rv_cur;
          rres <= r_ge ? (rres_cur >> 1) + rbit_cur : (rres_cur >> 1);
          rbit <= rbit_cur >> 2;
        end
        cnt <= cnt + 6'd1;
      end
      S_CMP: begin
        if (arm_idx > best) begin
          best     <= arm_idx;
          best_arm <= ai;
        end
        ai <= ai + AW'(1);
      end
      S_RDP, S_ARD, S_FIN: begin
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/ucb1_chk.sv
// ------------------------------------------------------------------------
// ucb1_chk
// Port-level checks for the UCB1 arm selector, bound to the top level.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ucb1_chk #(
  parameter int MAX_ARMS = ucb1_pkg::DEF_MAX_ARMS
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic [ucb1_pkg::REWARD_W-1:0] reward,
  input wire logic [ucb1_pkg::COUNT_W-1:0]  pull_count,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [ucb1_pkg::ARM_W-1:0]    chosen_arm,
  input wire logic                          pready
);

  import ucb1_pkg::*;

  logic [COUNT_W+REWARD_W-1:0] in_beat;
  assign in_beat = {pull_count, reward};

  // source side keeps a stalled beat
  `UCB1_HOLD(a_in_hold, clk, rst, in_valid, in_ready, in_beat, "input beat changed while stalled")

  // result register keeps a stalled beat
  `UCB1_HOLD(a_out_hold, clk, rst, out_valid, out_ready, chosen_arm, "result changed while stalled")

  // one item at a time: an accepted beat closes the input side
  `UCB1_ASSERT(a_one_item, clk, rst, (in_valid && in_ready) |=> !in_ready, "second beat taken while busy")

  // the chosen arm always lies among the built arms, config port always ready
  `UCB1_ASSERT(a_arm_range, clk, rst, (!out_valid || (32'(chosen_arm) < 32'(MAX_ARMS) || MAX_ARMS >= 32)) && pready, "arm out of range")

endmodule

bind ucb1_arm_selector_unit ucb1_chk #(.MAX_ARMS(MAX_ARMS)) u_chk (.*);

`default_nettype wire

// File: verif/ucb1_arm_selector_unit_tb.sv
// ------------------------------------------------------------------------
// ucb1_arm_selector_unit_tb
// Self-checking bench for the UCB1 arm selector: a fixed-point predictor
// tracks reward sums, pull counts and the chosen arm, and every output beat
// is compared in order against it under varied num_arms and flow control.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ucb1_arm_selector_unit_tb;
  import ucb1_pkg::*;

  localparam int ARMS       = DEF_MAX_ARMS;
  localparam int IDLE_LIMIT = 40000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [REWARD_W-1:0] reward = '0;
  logic [COUNT_W-1:0]  pull_count = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [ARM_W-1:0]    chosen_arm;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  ucb1_arm_selector_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .reward(reward), .pull_count(pull_count),
    .out_valid(out_valid), .out_ready(out_ready), .chosen_arm(chosen_arm),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [SUM_W-1:0]   sum_mdl [ARMS];
  logic [PULL_W-1:0]  pulls_mdl [ARMS];
  logic [ARM_W-1:0]   last_arm_mdl;
  logic [NARMS_W-1:0] num_arms_mdl;
  logic [ARM_W-1:0]   arm_q [$];

  // flow control knobs and bookkeeping
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int index_steps = 0;
  int quiet_cycles = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // natural log of x in Q16.16 via log2 by repeated squaring
  function automatic logic [63:0] ln_fix(logic [63:0] x);
    logic [63:0] t, m;
    logic [31:0] frac;
    int k;
    t = x;
    k = 0;
    frac = '0;
    while (t > 1 && k < 63) begin
      t = t >> 1;
      k++;
    end
    if (k <= 30) m = x << (30 - k);
    else m = x >> (k - 30);
    for (int b = 0; b < FRAC_BITS; b++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return (((64'(k) << 16) | 64'(frac)) * 64'(LN2_Q16)) >> 16;
  endfunction

  // digit-by-digit integer square root
  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] res, bitv;
    res = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] ucb_index(int arm, logic [63:0] ln2x);
    logic [63:0] p, mean, bonus, s;
    p = 64'(pulls_mdl[arm]);
    if (p == 0) return IDX_MAX;
    mean = 64'(sum_mdl[arm]) / p;
    if (mean > 64'hFFFF_FFFF) mean = 64'hFFFF_FFFF;
    bonus = isqrt64((ln2x / p) << 16);
    s = mean + bonus;
    if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
    return s[31:0];
  endfunction

  // advance the predictor by one accepted beat, return the next arm
  function automatic logic [ARM_W-1:0] next_arm(logic [REWARD_W-1:0] rw,
                                                logic [COUNT_W-1:0] cnt);
    int n, prev, best_arm;
    logic [63:0] s, ln2x;
    logic [31:0] best, v;
    n = (num_arms_mdl == 0) ? 1 : (num_arms_mdl > ARMS) ? ARMS : int'(num_arms_mdl);
    prev = int'(last_arm_mdl);
    if (cnt == 0) begin
      for (int i = 0; i < ARMS; i++) begin
        sum_mdl[i] = '0;
        pulls_mdl[i] = '0;
      end
      last_arm_mdl = '0;
    end else if (64'(cnt) < 64'(n)) begin
      sum_mdl[prev] = SUM_W'(rw);
      if (pulls_mdl[prev] != PULL_MAX) pulls_mdl[prev]++;
      last_arm_mdl = cnt[ARM_W-1:0];
    end else begin
      s = 64'(sum_mdl[prev]) + 64'(rw);
      sum_mdl[prev] = (s > 64'(SUM_MAX)) ? SUM_MAX : s[SUM_W-1:0];
      if (pulls_mdl[prev] != PULL_MAX) pulls_mdl[prev]++;
      ln2x = 2 * ln_fix(64'(cnt) + 1);
      best = ucb_index(0, ln2x);
      best_arm = 0;
      for (int i = 1; i < n; i++) begin
        v = ucb_index(i, ln2x);
        if (v > best) begin
          best = v;
          best_arm = i;
        end
      end
      last_arm_mdl = ARM_W'(best_arm);
      index_steps++;
    end
    return last_arm_mdl;
  endfunction

  // one input beat, with an optional idle gap in front
  task automatic send_beat(logic [REWARD_W-1:0] rw, logic [COUNT_W-1:0] cnt);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    reward     <= rw;
    pull_count <= cnt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    arm_q.push_back(next_arm(rw, cnt));
    beats_in++;
  endtask

  // called at the edge that took the last beat, so valid drops right away
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (arm_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // APB write of num_arms, only with the unit idle
  task automatic set_num_arms(logic [NARMS_W-1:0] val);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_NUM_ARMS, 2'b00};
    pwdata  <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    num_arms_mdl = val;
    @(posedge clk);
  endtask

  // result checking and receiver flow control
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        beats_out++;
        if (arm_q.size() == 0) begin
          $display("%0t: unexpected beat, actual arm %0d", $time, chosen_arm);
          errors++;
        end else begin
          if (chosen_arm !== arm_q[0]) begin
            $display("%0t: chosen_arm mismatch, expected %0d actual %0d",
                     $time, arm_q[0], chosen_arm);
            errors++;
          end
          void'(arm_q.pop_front());
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IDLE_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, arm_q.size());
      $display("ucb1_arm_selector_unit_tb: done, errors");
      $finish;
    end
  end

  function automatic logic [REWARD_W-1:0] rand_reward();
    case ($urandom_range(9))
      0: return '0;
      1: return REWARD_W'(65536);
      2: return '1;
      default: return REWARD_W'($urandom_range(131071));
    endcase
  endfunction

  // restart, fill phase, index phase, big counts and saturating rewards
  task automatic test_directed;
    send_beat(REWARD_W'(0), 32'd0);
    send_beat(REWARD_W'(65536), 32'd1);
    send_beat(REWARD_W'(0), 32'd2);
    send_beat('1, 32'd3);
    send_beat(REWARD_W'(100), 32'd4);
    send_beat(REWARD_W'(65536), 32'd5);
    send_beat('1, 32'd6);
    send_beat(REWARD_W'(0), 32'd7);
    send_beat('1, 32'hFFFF_FFFF);
    send_beat('1, 32'hFFFF_FFFE);
    send_beat(REWARD_W'(1), 32'h8000_0000);
    send_beat(REWARD_W'(0), 32'd0);
    send_beat(REWARD_W'(0), 32'd9);
    send_beat(REWARD_W'(65536), 32'h5555_5555);
    send_beat(REWARD_W'(1), 32'hAAAA_AAAA);
    send_beat(REWARD_W'(0), 32'd0);
  endtask

  // a short well-formed sequence from restart
  task automatic run_sequence(int len);
    send_beat(rand_reward(), 32'd0);
    for (int c = 1; c <= len; c++) send_beat(rand_reward(), 32'(c));
  endtask

  // num_arms zero, one, above range and the full count
  task automatic test_arm_count_extremes;
    set_num_arms(6'd0);
    run_sequence(4);
    set_num_arms(6'd1);
    run_sequence(3);
    set_num_arms(6'd63);
    run_sequence(34);
    set_num_arms(6'd32);
    send_beat('1, 32'd0);
    send_beat('1, 32'hFFFF_FFFF);
    run_sequence(33);
    set_num_arms(6'd2);
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_pressure;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_num_arms(6'd3);
    hold_left = 3000;
    run_sequence(9);
  endtask

  // random phases, mostly well-formed sequences with some noise
  task automatic random_phase(int items, int idle_pct, int stall_pct);
    logic [COUNT_W-1:0] cnt;
    set_num_arms(NARMS_W'($urandom_range(2, 7)));
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    cnt = '0;
    for (int i = 0; i < items; i++) begin
      case ($urandom_range(19))
        0: cnt = '0;
        1, 2: cnt = $urandom();
        default: ;
      endcase
      send_beat(rand_reward(), cnt);
      cnt++;
    end
  endtask

  task automatic test_random_phases;
    random_phase(70, 0, 0);
    random_phase(65, 73, 0);
    random_phase(65, 0, 73);
    random_phase(65, 32, 32);
  endtask

  initial begin
    num_arms_mdl = NARMS_RST;
    last_arm_mdl = '0;
    for (int i = 0; i < ARMS; i++) begin
      sum_mdl[i] = '0;
      pulls_mdl[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_arm_count_extremes();
    test_pressure();
    test_random_phases();
    drain();

    $display("Covered %0d input beats, %0d results, %0d index-phase decisions,",
             beats_in, beats_out, index_steps);
    $display("num_arms 0/1/2..7/32/63, long receiver hold-off and four idling mixes.");
    if (errors == 0) begin
      $display("ucb1_arm_selector_unit_tb: done, clean");
    end else begin
      $display("ucb1_arm_selector_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
